@@ hw/rtl/tgarle_pkg.sv @@
// Shared types and constants for the TGA run-length pixel decoder.
package tgarle_pkg;

   localparam int BYTE_W       = 8;
   localparam int PIX_W        = 32;
   localparam int CSR_DATA_W   = 25;
   localparam int CSR_INDEX_W  = 2;
   localparam int RUN_W        = 8;
   localparam int BPP_W        = 3;
   localparam int RSP_DATA_W   = 40;

   localparam logic [BPP_W-1:0] BPP_ARGB1555 = 3'd2;
   localparam logic [BPP_W-1:0] BPP_BGR      = 3'd3;
   localparam logic [BPP_W-1:0] BPP_BGRA     = 3'd4;

   localparam int HDR_REPEAT_BIT = 7;
   localparam logic [7:0] HDR_COUNT_MASK = 8'h7f;

   localparam logic [7:0] MASK_RED_HI   = 8'h7c;
   localparam logic [7:0] MASK_GREEN_HI = 8'h03;
   localparam logic [7:0] MASK_GREEN_LO = 8'he0;
   localparam logic [7:0] MASK_BLUE     = 8'h1f;
   localparam logic [7:0] MASK_ALPHA1   = 8'h80;
   localparam logic [7:0] ALPHA_OPAQUE  = 8'd255;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RLE_MODE    = 2'd0,
      CSR_BPP         = 2'd1,
      CSR_PIXEL_COUNT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rgba_type;

endpackage

@@ hw/rtl/tgarle_color.sv @@
// Pixel format conversion: ARGB1555, BGR or BGRA bytes to RGBA.
module tgarle_color (
   input  logic [tgarle_pkg::PIX_W-1:0] pixel_bytes,
   input  logic [tgarle_pkg::BPP_W-1:0] bpp,
   output tgarle_pkg::rgba_type         color
);

   logic [7:0] b0, b1, b2, b3;

   assign b0 = pixel_bytes[7:0];
   assign b1 = pixel_bytes[15:8];
   assign b2 = pixel_bytes[23:16];
   assign b3 = pixel_bytes[31:24];

   always_comb begin
      if (bpp == tgarle_pkg::BPP_ARGB1555) begin
         // expand 5-bit channels by shifting up, no replication of low bits
         color.red   = {b1[6:2] & tgarle_pkg::MASK_RED_HI[6:2], 3'b000};
         color.green = {b1[1:0] & tgarle_pkg::MASK_GREEN_HI[1:0],
                        b0[7:5] & tgarle_pkg::MASK_GREEN_LO[7:5], 3'b000};
         color.blue  = {b0[4:0] & tgarle_pkg::MASK_BLUE[4:0], 3'b000};
         color.alpha = b1 & tgarle_pkg::MASK_ALPHA1;
      end else begin
         color.red   = b2;
         color.green = b1;
         color.blue  = b0;
         color.alpha = (bpp == tgarle_pkg::BPP_BGRA) ? b3 : tgarle_pkg::ALPHA_OPAQUE;
      end
   end

endmodule

@@ hw/rtl/tga_rle_pixel_decoder.sv @@
// TGA pixel-data decoder, uncompressed or run-length, one byte per beat.
//
// Takes one byte of TGA pixel data per cycle and emits one RGBA pixel with a
// run length when a pixel completes; header bytes and partial pixels give no
// output. Each byte is decoded in the cycle it is accepted and the result is
// held in an output register, so the block sustains one byte per clock; it
// stalls only while a held result is not taken. A run that would pass the
// configured pixel count is shortened, the run that reaches the count is
// marked with tlast, and after it bytes are dropped until a beat arrives with
// tuser set.
module tga_rle_pixel_decoder #(
   parameter int PIXEL_COUNT_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [tgarle_pkg::BYTE_W-1:0]        req_tdata,   // [7:0] data_byte
   input  logic                                 req_tuser,   // [0] start_of_image
   // result channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [39:32] run_length
   output logic [tgarle_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                                 rsp_tlast,   // image_done
   // configuration
   input  logic                                 csr_we,
   input  logic [tgarle_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tgarle_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int LIM_W = PIXEL_COUNT_BITS + 1;

   // configuration
   logic                         rle_ff, rle_in;
   logic [tgarle_pkg::BPP_W-1:0] bpp_ff, bpp_in;
   logic [LIM_W-1:0]             lim_ff, lim_in;
   logic [32:0]                  cap_w, pc_w, lim_w;

   // decode state
   logic                          await_ff, await_in;
   logic [1:0]                    pos_ff, pos_in;
   logic [tgarle_pkg::PIX_W-1:0]  pix_ff, pix_in;
   logic                          rep_ff, rep_in;
   logic [tgarle_pkg::RUN_W-1:0]  rem_ff, rem_in;
   logic [LIM_W-1:0]              pd_ff, pd_in;
   logic                          fin_ff, fin_in;

   // state after an optional start-of-image clear
   logic                          s_await;
   logic [1:0]                    s_pos;
   logic [tgarle_pkg::PIX_W-1:0]  s_pix, pix_new;
   logic                          s_rep;
   logic [tgarle_pkg::RUN_W-1:0]  s_rem;
   logic [LIM_W-1:0]              s_pd;
   logic                          s_fin;

   logic                          accept, emit;
   logic [tgarle_pkg::RUN_W-1:0]  run_raw, run_out;
   logic [LIM_W:0]                sum;
   logic [LIM_W-1:0]              gap;
   logic                          pd_lt, clip;
   logic [7:0]                    byte_in;
   tgarle_pkg::rgba_type          color;

   // output register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [tgarle_pkg::RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                               rsp_last_ff, rsp_last_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign byte_in    = req_tdata;

   // configuration writes; limit is clamped to [1, 2^PIXEL_COUNT_BITS] here
   assign cap_w = 33'(1) << PIXEL_COUNT_BITS;
   assign pc_w  = (csr_wdata == '0) ? 33'(1) : 33'(csr_wdata);
   assign lim_w = (pc_w > cap_w) ? cap_w : pc_w;

   always_comb begin
      rle_in = rle_ff;
      bpp_in = bpp_ff;
      lim_in = lim_ff;
      if (csr_we) begin
         unique case (csr_index)
            tgarle_pkg::CSR_RLE_MODE: rle_in = csr_wdata[0];
            tgarle_pkg::CSR_BPP: begin
               if (csr_wdata[2:0] < tgarle_pkg::BPP_ARGB1555) begin
                  bpp_in = tgarle_pkg::BPP_ARGB1555;
               end else if (csr_wdata[2:0] > tgarle_pkg::BPP_BGRA) begin
                  bpp_in = tgarle_pkg::BPP_BGRA;
               end else begin
                  bpp_in = csr_wdata[2:0];
               end
            end
            tgarle_pkg::CSR_PIXEL_COUNT: lim_in = lim_w[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   // start-of-image clears decode state before the byte is used
   assign s_await = req_tuser ? rle_ff : await_ff;
   assign s_pos   = req_tuser ? 2'd0 : pos_ff;
   assign s_pix   = req_tuser ? '0 : pix_ff;
   assign s_rep   = req_tuser ? 1'b0 : rep_ff;
   assign s_rem   = req_tuser ? '0 : rem_ff;
   assign s_pd    = req_tuser ? '0 : pd_ff;
   assign s_fin   = req_tuser ? 1'b0 : fin_ff;

   always_comb begin
      pix_new = s_pix;
      pix_new[{s_pos, 3'b000} +: 8] = byte_in;
   end

   tgarle_color u_color (
      .pixel_bytes (pix_new),
      .bpp         (bpp_ff),
      .color       (color)
   );

   // a repeat packet spends all its pixels in one beat
   assign run_raw = (rle_ff && s_rep) ? s_rem : 8'd1;

   // run clipping against the pixel limit, all compares in parallel
   assign pd_lt = s_pd < lim_ff;
   assign sum   = {1'b0, s_pd} + (LIM_W+1)'(run_raw);
   assign gap   = lim_ff - s_pd;
   assign clip  = pd_lt ? (sum > {1'b0, lim_ff}) : (run_raw > 8'd1);
   assign run_out = clip ? (pd_lt ? gap[7:0] : 8'd1) : run_raw;

   always_comb begin
      await_in = await_ff;
      pos_in   = pos_ff;
      pix_in   = pix_ff;
      rep_in   = rep_ff;
      rem_in   = rem_ff;
      pd_in    = pd_ff;
      fin_in   = fin_ff;
      emit     = 1'b0;
      if (accept) begin
         await_in = s_await;
         pos_in   = s_pos;
         pix_in   = s_pix;
         rep_in   = s_rep;
         rem_in   = s_rem;
         pd_in    = s_pd;
         fin_in   = s_fin;
         if (!s_fin) begin
            if (rle_ff && (s_await || s_rem == '0)) begin
               // packet header
               rep_in   = byte_in[tgarle_pkg::HDR_REPEAT_BIT];
               rem_in   = (byte_in & tgarle_pkg::HDR_COUNT_MASK) + 8'd1;
               await_in = 1'b0;
               pos_in   = 2'd0;
            end else begin
               pix_in = pix_new;
               if ({1'b0, s_pos} + 3'd1 < bpp_ff) begin
                  pos_in = s_pos + 2'd1;
               end else begin
                  pos_in = 2'd0;
                  emit   = 1'b1;
                  if (rle_ff) begin
                     if (s_rep) begin
                        rem_in   = '0;
                        await_in = 1'b1;
                     end else begin
                        rem_in   = s_rem - 8'd1;
                        await_in = (s_rem == 8'd1);
                     end
                  end
                  if (clip) begin
                     pd_in = pd_lt ? lim_ff : s_pd + LIM_W'(1);
                  end else begin
                     pd_in = sum[LIM_W-1:0];
                  end
                  fin_in = clip || (sum >= {1'b0, lim_ff});
               end
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (accept && emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {run_out, color.alpha, color.blue, color.green, color.red};
         rsp_last_in  = fin_in;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rle_ff       <= 1'b0;
         bpp_ff       <= tgarle_pkg::BPP_BGR;
         lim_ff       <= LIM_W'(1);
         await_ff     <= 1'b0;
         pos_ff       <= 2'd0;
         pix_ff       <= '0;
         rep_ff       <= 1'b0;
         rem_ff       <= '0;
         pd_ff        <= '0;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rle_ff       <= rle_in;
         bpp_ff       <= bpp_in;
         lim_ff       <= lim_in;
         await_ff     <= await_in;
         pos_ff       <= pos_in;
         pix_ff       <= pix_in;
         rep_ff       <= rep_in;
         rem_ff       <= rem_in;
         pd_ff        <= pd_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ hw/rtl/tgarle_checker.sv @@
// Port-level checks for the TGA run-length pixel decoder, bound to the top level.
module tgarle_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [tgarle_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic                                rsp_tlast
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   // input side stops while a result waits
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input accepted while result stalled");

   // a new result follows an accepted byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !$past(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("result without accepted byte");

   // run length is between 1 and 128
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:32] != 8'd0 && rsp_tdata[39:32] <= 8'd128)
      else $error("run length out of range");

endmodule

bind tga_rle_pixel_decoder tgarle_checker u_tgarle_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
